// ----- rtl/huffman_bit_serial_decoder_top_macros.svh -----
// Assertion macros for the prefix-code decoder checker.
// No dependencies; included by the checker file.
`ifndef HUFFMAN_BIT_SERIAL_DECODER_TOP_MACROS_SVH
`define HUFFMAN_BIT_SERIAL_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define HBSD_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("hbsd: same-cycle check failed");

// next-cycle implication
`define HBSD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("hbsd: next-cycle check failed");

`endif

// ----- rtl/hbsd_pkg.sv -----
// Shared constants, codes and control types of the prefix-code decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hbsd_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int MAX_CODE_LEN  = 24;
	localparam int LEN_LIMIT     = (MAX_CODE_LEN < 24) ? MAX_CODE_LEN : 24;

	localparam int CODE_W = 24;
	localparam int LEN_W  = 5;
	localparam int SYM_W  = 8;
	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

	localparam logic [LEN_W-1:0] LEN_LIMIT_V = LEN_W'(LEN_LIMIT);
	localparam logic [CNT_W-1:0] TABLE_FULL_V = CNT_W'(TABLE_ENTRIES);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	typedef enum logic [2:0] {
		ST_SYMBOL  = 3'd0,
		ST_LOADED  = 3'd1,
		ST_CLEARED = 3'd2,
		ST_FULL    = 3'd3,
		ST_TOOLONG = 3'd4
	} status_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [SYM_W-1:0]  sym;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic    clear_tbl;
		logic    key_load;
		logic    scan_start;
		logic    shift_bit;
		logic    write_hit;
		logic    write_new;
		logic    push;
		status_t push_status;
		logic    clr_partial;
		logic    flush;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_len;
		logic scan_hit;
		logic scan_miss;
		logic full;
		logic len_seen;
		logic at_limit;
		logic more_bits;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/huffman_bit_serial_decoder_top.sv -----
// Top level of the bit-serial prefix-code decoder.
// Depends on hbsd_pkg, hbsd_ctrl and hbsd_datapath.
//
//  channel   strobe / accept                fields
//  -------   ----------------------------   ----------------------------------------
//  request   start & !busy at clk edge      op, code_bits, code_length, symbol,
//                                           data_byte, last_byte, padding_bits
//  result    result_valid, one cycle each   decoded_symbol, status, last_result
//
// Sequence: a clear needs no scan. A load with a valid length scans the
// stored entries in order, up to the first match, through the single read
// port of the table memory. A decode consumes the data bits one at a time
// and scans the table again for each bit whose accumulator length matches
// the length of some stored code.
// Reset: arst_n clears the controller, entry count, length-present mask,
// accumulator and result strobe; table contents are never cleared (entries
// at or above the count are ignored).
// Stalls: none on the result side; busy holds off new requests until the
// final result of the current one has been issued.
`timescale 1ns / 1ps
`default_nettype none

module huffman_bit_serial_decoder_top import hbsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [CODE_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_length,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [2:0]        padding_bits,
	output logic              result_valid,
	output logic [SYM_W-1:0]  decoded_symbol,
	output logic [2:0]        status,
	output logic              last_result
);

	cmd_t cmd;
	sts_t sts;
	logic accept;

	// request handshake
	assign accept = start && !busy;

	// sequencing of the clear and load steps and of each consumed bit
	hbsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table, scan unit, accumulator and result registers
	hbsd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.op             (op),
		.code_bits      (code_bits),
		.code_length    (code_length),
		.symbol         (symbol),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.padding_bits   (padding_bits),
		.cmd            (cmd),
		.sts            (sts),
		.result_valid   (result_valid),
		.decoded_symbol (decoded_symbol),
		.status         (status),
		.last_result    (last_result)
	);

endmodule

`default_nettype wire

// ----- rtl/hbsd_datapath.sv -----
// Datapath: request registers, code table memory, linear scan unit,
// bit accumulator and the one-deep result hold. Depends on hbsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbsd_datapath import hbsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        op,
	input  logic [CODE_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_length,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [2:0]        padding_bits,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic              result_valid,
	output logic [SYM_W-1:0]  decoded_symbol,
	output logic [2:0]        status,
	output logic              last_result
);

	// request
	logic [1:0]        req_op_q;
	logic [CODE_W-1:0] req_code_q;
	logic [LEN_W-1:0]  req_len_q;
	logic [SYM_W-1:0]  req_sym_q;
	logic [7:0]        req_byte_q;
	logic              req_last_q;
	logic [2:0]        req_stop_q;
	logic [2:0]        bit_q;
	logic              more_q;

	// table
	entry_t                   mem [TABLE_ENTRIES];
	entry_t                   rd_data_q;
	logic [CNT_W-1:0]         count_q;
	logic [(1<<LEN_W)-1:0]    len_seen_q;

	// scan
	logic             scanning_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             cmp_vld_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             rd_more;
	logic             match;

	// accumulator
	logic [CODE_W-1:0] part_code_q;
	logic [LEN_W-1:0]  part_len_q;

	// results
	logic              pend_vld_q;
	logic [SYM_W-1:0]  pend_sym_q;
	status_t           pend_st_q;
	logic              res_vld_q;
	logic [SYM_W-1:0]  res_sym_q;
	status_t           res_st_q;
	logic              res_last_q;

	logic [CODE_W-1:0] key_code;
	logic [LEN_W-1:0]  key_len;
	logic [SYM_W-1:0]  push_sym;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	entry_t            wdata;

	assign key_code = cmd.key_load ? req_code_q : part_code_q;
	assign key_len  = cmd.key_load ? req_len_q  : part_len_q;

	assign rd_more = scanning_q && (rd_idx_q < count_q);
	assign match   = (rd_data_q.code == key_code) && (rd_data_q.len == key_len);

	assign sts.bad_len   = (req_len_q == '0) || (req_len_q > LEN_LIMIT_V);
	assign sts.scan_hit  = scanning_q && cmp_vld_q && match;
	assign sts.scan_miss = scanning_q && !cmp_vld_q && !rd_more;
	assign sts.full      = (count_q == TABLE_FULL_V);
	assign sts.len_seen  = len_seen_q[part_len_q];
	assign sts.at_limit  = (part_len_q >= LEN_LIMIT_V);
	assign sts.more_bits = more_q;

	assign we    = cmd.write_hit || cmd.write_new;
	assign waddr = cmd.write_hit ? cmp_idx_q : count_q[IDX_W-1:0];
	assign wdata = '{code: req_code_q, len: req_len_q, sym: req_sym_q};

	assign push_sym = (cmd.push_status == ST_SYMBOL) ? rd_data_q.sym : '0;

	// request capture and bit pointer
	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q   <= op;
			req_code_q <= code_bits & ~({CODE_W{1'b1}} << code_length);
			req_len_q  <= code_length;
			req_sym_q  <= symbol;
			req_byte_q <= data_byte;
			req_last_q <= last_byte;
			req_stop_q <= last_byte ? padding_bits : 3'd0;
			bit_q      <= 3'd7;
		end else if (cmd.shift_bit) begin
			more_q <= (bit_q > req_stop_q);
			bit_q  <= bit_q - 3'd1;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (rd_more) begin
			rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
			cmp_idx_q <= rd_idx_q[IDX_W-1:0];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// table bookkeeping, scan and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			len_seen_q  <= '0;
			scanning_q  <= 1'b0;
			rd_idx_q    <= '0;
			cmp_vld_q   <= 1'b0;
			part_code_q <= '0;
			part_len_q  <= '0;
		end else begin
			if (cmd.clear_tbl) begin
				count_q    <= '0;
				len_seen_q <= '0;
			end else if (cmd.write_new) begin
				count_q               <= count_q + 1'b1;
				len_seen_q[req_len_q] <= 1'b1;
			end

			if (cmd.scan_start) begin
				scanning_q <= 1'b1;
				rd_idx_q   <= '0;
				cmp_vld_q  <= 1'b0;
			end else begin
				if (sts.scan_hit || sts.scan_miss) begin
					scanning_q <= 1'b0;
				end
				if (rd_more) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				cmp_vld_q <= rd_more;
			end

			if (cmd.clear_tbl || cmd.clr_partial ||
			    (cmd.flush && req_op_q == OP_DECODE && req_last_q)) begin
				part_code_q <= '0;
				part_len_q  <= '0;
			end else if (cmd.shift_bit) begin
				part_code_q <= {part_code_q[CODE_W-2:0], req_byte_q[bit_q]};
				part_len_q  <= part_len_q + 1'b1;
			end
		end
	end

	// a result is held back one step so the last one of a request can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			if (cmd.push) begin
				res_vld_q  <= pend_vld_q;
				pend_vld_q <= 1'b1;
			end else if (cmd.flush && pend_vld_q) begin
				res_vld_q  <= 1'b1;
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_sym_q  <= pend_sym_q;
			res_st_q   <= pend_st_q;
			res_last_q <= 1'b0;
			pend_sym_q <= push_sym;
			pend_st_q  <= cmd.push_status;
		end else if (cmd.flush) begin
			res_sym_q  <= pend_sym_q;
			res_st_q   <= pend_st_q;
			res_last_q <= 1'b1;
		end
	end

	assign result_valid   = res_vld_q;
	assign decoded_symbol = res_sym_q;
	assign status         = res_st_q;
	assign last_result    = res_last_q;

endmodule

`default_nettype wire

// ----- rtl/hbsd_ctrl.sv -----
// Controller state machine: sequences clear, load and per-bit decode.
// Depends on hbsd_pkg; drives the datapath through cmd_t / sts_t.
`timescale 1ns / 1ps
`default_nettype none

module hbsd_ctrl import hbsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] op,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CLEAR = 8'b0000_0010,
		S_LCHK  = 8'b0000_0100,
		S_LSCAN = 8'b0000_1000,
		S_BIT   = 8'b0001_0000,
		S_BCHK  = 8'b0010_0000,
		S_BSCAN = 8'b0100_0000,
		S_FLUSH = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_bit;

	assign busy      = (state_q != S_IDLE);
	assign after_bit = sts.more_bits ? S_BIT : S_FLUSH;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_CLEAR:  state_d = S_CLEAR;
						OP_LOAD:   state_d = S_LCHK;
						OP_DECODE: state_d = S_BIT;
						OP_NONE:   state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clear_tbl   = 1'b1;
				cmd.push        = 1'b1;
				cmd.push_status = ST_CLEARED;
				state_d         = S_FLUSH;
			end
			S_LCHK: begin
				cmd.key_load = 1'b1;
				if (sts.bad_len) begin
					cmd.push        = 1'b1;
					cmd.push_status = ST_TOOLONG;
					state_d         = S_FLUSH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_LSCAN;
				end
			end
			S_LSCAN: begin
				cmd.key_load = 1'b1;
				if (sts.scan_hit) begin
					cmd.write_hit   = 1'b1;
					cmd.push        = 1'b1;
					cmd.push_status = ST_LOADED;
					state_d         = S_FLUSH;
				end else if (sts.scan_miss) begin
					cmd.push = 1'b1;
					if (sts.full) begin
						cmd.push_status = ST_FULL;
					end else begin
						cmd.write_new   = 1'b1;
						cmd.push_status = ST_LOADED;
					end
					state_d = S_FLUSH;
				end
			end
			S_BIT: begin
				cmd.shift_bit = 1'b1;
				state_d       = S_BCHK;
			end
			S_BCHK: begin
				if (sts.len_seen) begin
					cmd.scan_start = 1'b1;
					state_d        = S_BSCAN;
				end else begin
					if (sts.at_limit) begin
						cmd.push        = 1'b1;
						cmd.push_status = ST_TOOLONG;
						cmd.clr_partial = 1'b1;
					end
					state_d = after_bit;
				end
			end
			S_BSCAN: begin
				if (sts.scan_hit) begin
					cmd.push        = 1'b1;
					cmd.push_status = ST_SYMBOL;
					cmd.clr_partial = 1'b1;
					state_d         = after_bit;
				end else if (sts.scan_miss) begin
					if (sts.at_limit) begin
						cmd.push        = 1'b1;
						cmd.push_status = ST_TOOLONG;
						cmd.clr_partial = 1'b1;
					end
					state_d = after_bit;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hbsd_checker.sv -----
// Port-level checker for the prefix-code decoder, bound to the top level.
// Depends on hbsd_pkg and huffman_bit_serial_decoder_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_bit_serial_decoder_top_macros.svh"

module hbsd_checker import hbsd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        op,
	input logic              result_valid,
	input logic [SYM_W-1:0]  decoded_symbol,
	input logic [2:0]        status,
	input logic              last_result
);

	logic status_known;
	logic table_status;
	logic real_accept;

	assign status_known = (status == ST_SYMBOL) || (status == ST_LOADED) ||
	                      (status == ST_CLEARED) || (status == ST_FULL) ||
	                      (status == ST_TOOLONG);
	assign table_status = (status == ST_LOADED) || (status == ST_CLEARED) ||
	                      (status == ST_FULL);
	assign real_accept  = start && !busy && (op != OP_NONE);

	// only defined status codes leave the block
	`HBSD_ASSERT_IMP(a_status_code, clk, arst_n, result_valid, status_known)

	// symbol field is zero on every non-symbol result
	`HBSD_ASSERT_IMP(a_sym_zero, clk, arst_n, result_valid && status != ST_SYMBOL, decoded_symbol == '0)

	// table requests give exactly one result, so it is always the last
	`HBSD_ASSERT_IMP(a_table_last, clk, arst_n, result_valid && table_status, last_result)

	// the final result of a request coincides with the block going idle
	`HBSD_ASSERT_IMP(a_last_idle, clk, arst_n, result_valid && last_result, !busy)

	// a real request makes the block busy
	`HBSD_ASSERT_NXT(a_accept_busy, clk, arst_n, real_accept, busy)

endmodule

bind huffman_bit_serial_decoder_top hbsd_checker u_hbsd_checker (.*);

`default_nettype wire
